// File: hdl/hme_pkg.sv
package hme_pkg;

	localparam int MAX_BINS_DEF = 256;
	localparam int SAMPLE_FRAC_BITS_DEF = 4;

	localparam int CNT_W = 32;
	localparam int DIV_W = 64;
	localparam int DVS_W = 33;
	localparam int RES_W = 24;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [RES_W-1:0] RES_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] REG_LOW_EDGE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BINS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_ENTRIES = 2'd2;

	localparam logic signed [11:0] LOW_EDGE_RST = 12'sd0;
	localparam logic [8:0] BINS_RST = 9'd200;
	localparam logic [15:0] MIN_ENTRIES_RST = 16'd10;

	typedef struct packed {
		logic mode;
		logic signed [15:0] sample;
	} in_item_t;

	typedef struct packed {
		logic signed [23:0] median;
		logic [23:0] median_error;
		logic enough_entries;
		logic [31:0] entry_total;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_SUM,
		ST_SCAN,
		ST_DRAIN,
		ST_PREP,
		ST_FRAC_GO,
		ST_FRAC_WAIT,
		ST_ERR1_GO,
		ST_ERR1_WAIT,
		ST_ERR2_GO,
		ST_ERR2_WAIT,
		ST_EMIT
	} state_t;

endpackage

// File: hdl/hme_store.sv
module hme_store #(
	parameter int DEPTH = hme_pkg::MAX_BINS_DEF + 2
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [hme_pkg::CNT_W-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [hme_pkg::CNT_W-1:0] rdata
);

	logic [hme_pkg::CNT_W-1:0] mem [DEPTH];
	logic [hme_pkg::CNT_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/hme_divider.sv
module hme_divider (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [hme_pkg::DIV_W-1:0] dividend,
	input logic [hme_pkg::DVS_W-1:0] divisor,
	output logic done,
	output logic [hme_pkg::DIV_W-1:0] quotient
);

	localparam int REM_W = hme_pkg::DVS_W + 1;
	localparam int CW = $clog2(hme_pkg::DIV_W + 1);

	logic [hme_pkg::DIV_W-1:0] dvd_q;
	logic [REM_W-1:0] rem_q;
	logic [hme_pkg::DVS_W-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [REM_W-1:0] shifted;
	logic ge;

	assign shifted = {rem_q[REM_W-2:0], dvd_q[hme_pkg::DIV_W-1]};
	assign ge = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(hme_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? (shifted - {1'b0, dvs_q}) : shifted;
			dvd_q <= {dvd_q[hme_pkg::DIV_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quotient = dvd_q;

endmodule

// File: hdl/hme_sqrt.sv
module hme_sqrt (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [hme_pkg::DIV_W-1:0] radicand,
	output logic [hme_pkg::DIV_W/2-1:0] root
);

	localparam int RT_W = hme_pkg::DIV_W / 2;
	localparam int REM_W = RT_W + 3;
	localparam int CW = $clog2(RT_W + 1);

	logic [hme_pkg::DIV_W-1:0] x_q;
	logic [REM_W-1:0] rem_q;
	logic [RT_W-1:0] root_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic [REM_W-1:0] shifted;
	logic [REM_W-1:0] trial;
	logic ge;

	assign shifted = {rem_q[REM_W-3:0], x_q[hme_pkg::DIV_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge = shifted >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(RT_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= radicand;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q <= {x_q[hme_pkg::DIV_W-3:0], 2'b00};
			rem_q <= ge ? (shifted - trial) : shifted;
			root_q <= {root_q[RT_W-2:0], ge};
		end
	end

	assign root = root_q;

endmodule

// File: hdl/histogram_median_estimator_top.sv
// One sample item is accepted per cycle while the block is idle: the bin is read,
// incremented and written back through a registered-read memory, with forwarding between
// back-to-back samples to the same bin. A finish item runs a summing walk, a search walk
// that also clears the memory, and three serial 64-bit divisions, which are skipped when
// no median bin is found.
// After reset all MAX_BINS + 2 memory entries are cleared while input is stalled.
module histogram_median_estimator_top #(
	parameter int MAX_BINS = hme_pkg::MAX_BINS_DEF,
	parameter int SAMPLE_FRAC_BITS = hme_pkg::SAMPLE_FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input hme_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output hme_pkg::out_item_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [hme_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [hme_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int DEPTH = MAX_BINS + 2;
	localparam int AW = $clog2(DEPTH);
	localparam int NW = ($clog2(MAX_BINS + 1) > 9) ? $clog2(MAX_BINS + 1) : 9;
	localparam int ACC_W = hme_pkg::CNT_W + AW;
	localparam int CW = hme_pkg::CNT_W;

	hme_pkg::state_t state_q, state_d;

	logic signed [11:0] low_edge_q;
	logic [8:0] bins_q;
	logic [15:0] min_entries_q;

	logic [CW-1:0] sample_total_q;
	logic [CW-1:0] n_q;
	logic enough_q;

	logic [AW-1:0] addr_q;
	logic [NW-1:0] bins_ext;
	logic [AW-1:0] nb;
	logic [AW-1:0] last;

	logic in_acc;
	logic smp_acc;
	logic fin_acc;

	logic signed [15:0] whole;
	logic signed [17:0] rel;
	logic [AW-1:0] smp_idx;

	logic smp_valid_s1;
	logic [AW-1:0] smp_idx_s1;
	logic fwd_valid_q;
	logic [AW-1:0] fwd_idx_q;
	logic [CW-1:0] fwd_data_q;
	logic [CW-1:0] old_cnt;
	logic [CW-1:0] new_cnt;

	logic mem_we;
	logic [AW-1:0] mem_waddr;
	logic [CW-1:0] mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [CW-1:0] mem_rdata;

	logic rd_sum_s1;
	logic rd_scan_s1;
	logic [AW-1:0] rd_idx_s1;

	logic [ACC_W-1:0] total_q;
	logic [ACC_W-1:0] csum_q;
	logic [ACC_W-1:0] csum_next;
	logic found_q;
	logic [AW-1:0] fidx_q;
	logic [CW-1:0] fv_q;

	logic div_start;
	logic sqrt_start;
	logic div_done;
	logic [hme_pkg::DIV_W-1:0] div_dividend;
	logic [hme_pkg::DVS_W-1:0] div_divisor;
	logic [hme_pkg::DIV_W-1:0] div_quot;
	logic [hme_pkg::DIV_W/2-1:0] root;

	logic [ACC_W-1:0] gap;
	logic [hme_pkg::DIV_W-1:0] q1_q;
	logic [23:0] med_q;
	logic [23:0] err_q;
	logic [23:0] edge_ext;

	logic out_valid_q;
	hme_pkg::out_item_t out_q;
	logic out_load;

	assign in_stall = (state_q != hme_pkg::ST_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign smp_acc = in_acc && !in_data.mode;
	assign fin_acc = in_acc && in_data.mode;
	assign cfg_ready = 1'b1;

	always_comb begin
		bins_ext = NW'(bins_q);
		if (bins_ext == '0) begin
			nb = AW'(1);
		end else if (bins_ext > NW'(MAX_BINS)) begin
			nb = AW'(MAX_BINS);
		end else begin
			nb = AW'(bins_ext);
		end
		last = nb + 1'b1;
	end

	always_comb begin
		whole = in_data.sample >>> SAMPLE_FRAC_BITS;
		rel = 18'(whole) - 18'(low_edge_q);
		if (rel < 0) begin
			smp_idx = '0;
		end else if (rel >= $signed({1'b0, 17'(nb)})) begin
			smp_idx = last;
		end else begin
			smp_idx = AW'(rel) + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_edge_q <= hme_pkg::LOW_EDGE_RST;
			bins_q <= hme_pkg::BINS_RST;
			min_entries_q <= hme_pkg::MIN_ENTRIES_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				hme_pkg::REG_LOW_EDGE: low_edge_q <= cfg_data[11:0];
				hme_pkg::REG_BINS: bins_q <= cfg_data[8:0];
				hme_pkg::REG_MIN_ENTRIES: min_entries_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign old_cnt = (fwd_valid_q && fwd_idx_q == smp_idx_s1) ? fwd_data_q : mem_rdata;
	assign new_cnt = (old_cnt == hme_pkg::CNT_MAX) ? old_cnt : old_cnt + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_valid_s1 <= 1'b0;
			fwd_valid_q <= 1'b0;
			sample_total_q <= '0;
			rd_sum_s1 <= 1'b0;
			rd_scan_s1 <= 1'b0;
			state_q <= hme_pkg::ST_INIT;
			addr_q <= '0;
			out_valid_q <= 1'b0;
			found_q <= 1'b0;
			enough_q <= 1'b0;
		end else begin
			state_q <= state_d;
			smp_valid_s1 <= smp_acc;
			fwd_valid_q <= smp_valid_s1;
			rd_sum_s1 <= (state_q == hme_pkg::ST_SUM);
			rd_scan_s1 <= (state_q == hme_pkg::ST_SCAN);
			if (smp_acc && sample_total_q != hme_pkg::CNT_MAX) begin
				sample_total_q <= sample_total_q + 1'b1;
			end else if (fin_acc) begin
				sample_total_q <= '0;
			end
			case (state_q)
				hme_pkg::ST_INIT, hme_pkg::ST_SCAN: begin
					addr_q <= (addr_q == AW'(DEPTH - 1)) ? '0 : addr_q + 1'b1;
				end
				hme_pkg::ST_SUM: begin
					addr_q <= (addr_q == last) ? '0 : addr_q + 1'b1;
				end
				default: addr_q <= '0;
			endcase
			if (fin_acc) begin
				enough_q <= sample_total_q > CW'(min_entries_q);
				found_q <= 1'b0;
			end else if (rd_scan_s1 && enough_q && !found_q && total_q != '0
					&& mem_rdata != '0 && rd_idx_s1 <= last
					&& {csum_next, 1'b0} >= {1'b0, total_q}) begin
				found_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign csum_next = csum_q + ACC_W'(mem_rdata);

	always_ff @(posedge clk) begin
		smp_idx_s1 <= smp_idx;
		fwd_idx_q <= smp_idx_s1;
		fwd_data_q <= new_cnt;
		rd_idx_s1 <= addr_q;
		if (fin_acc) begin
			n_q <= sample_total_q;
			total_q <= '0;
			csum_q <= '0;
			med_q <= '0;
			err_q <= '0;
		end else begin
			if (rd_sum_s1) begin
				total_q <= total_q + ACC_W'(mem_rdata);
			end
			if (rd_scan_s1 && enough_q && !found_q && total_q != '0
					&& mem_rdata != '0 && rd_idx_s1 <= last) begin
				if ({csum_next, 1'b0} < {1'b0, total_q}) begin
					csum_q <= csum_next;
				end else begin
					fidx_q <= rd_idx_s1;
					fv_q <= mem_rdata;
				end
			end
			if (state_q == hme_pkg::ST_FRAC_WAIT && div_done) begin
				med_q <= {edge_ext[15:0], 8'h00} + div_quot[23:0];
			end
			if (state_q == hme_pkg::ST_ERR1_WAIT && div_done) begin
				q1_q <= div_quot;
				if (root == '0) begin
					err_q <= hme_pkg::RES_MAX;
				end
			end
			if (state_q == hme_pkg::ST_ERR2_WAIT && div_done) begin
				err_q <= (div_quot[hme_pkg::DIV_W-1:24] != '0) ? hme_pkg::RES_MAX
					: div_quot[23:0];
			end
		end
		if (out_load) begin
			out_q.median <= med_q;
			out_q.median_error <= err_q;
			out_q.enough_entries <= enough_q;
			out_q.entry_total <= n_q;
		end
	end

	assign edge_ext = 24'(low_edge_q) + 24'(fidx_q) - 24'd1;
	assign gap = total_q - {csum_q[ACC_W-2:0], 1'b0};

	always_comb begin
		state_d = state_q;
		case (state_q)
			hme_pkg::ST_INIT: if (addr_q == AW'(DEPTH - 1)) state_d = hme_pkg::ST_IDLE;
			hme_pkg::ST_IDLE: if (fin_acc) state_d = hme_pkg::ST_SUM;
			hme_pkg::ST_SUM: if (addr_q == last) state_d = hme_pkg::ST_SCAN;
			hme_pkg::ST_SCAN: if (addr_q == AW'(DEPTH - 1)) state_d = hme_pkg::ST_DRAIN;
			hme_pkg::ST_DRAIN: state_d = hme_pkg::ST_PREP;
			hme_pkg::ST_PREP: begin
				state_d = found_q ? hme_pkg::ST_FRAC_GO : hme_pkg::ST_EMIT;
			end
			hme_pkg::ST_FRAC_GO: state_d = hme_pkg::ST_FRAC_WAIT;
			hme_pkg::ST_FRAC_WAIT: if (div_done) state_d = hme_pkg::ST_ERR1_GO;
			hme_pkg::ST_ERR1_GO: state_d = hme_pkg::ST_ERR1_WAIT;
			hme_pkg::ST_ERR1_WAIT: begin
				if (div_done) begin
					state_d = (root == '0) ? hme_pkg::ST_EMIT : hme_pkg::ST_ERR2_GO;
				end
			end
			hme_pkg::ST_ERR2_GO: state_d = hme_pkg::ST_ERR2_WAIT;
			hme_pkg::ST_ERR2_WAIT: if (div_done) state_d = hme_pkg::ST_EMIT;
			hme_pkg::ST_EMIT: if (!out_valid_q) state_d = hme_pkg::ST_IDLE;
			default: state_d = hme_pkg::ST_INIT;
		endcase
	end

	always_comb begin
		div_start = 1'b0;
		sqrt_start = 1'b0;
		div_dividend = hme_pkg::DIV_W'({gap, 8'h00}) + hme_pkg::DIV_W'(fv_q);
		div_divisor = {fv_q, 1'b0};
		out_load = 1'b0;
		mem_we = smp_valid_s1;
		mem_waddr = smp_idx_s1;
		mem_wdata = new_cnt;
		mem_raddr = addr_q;
		case (state_q)
			hme_pkg::ST_INIT, hme_pkg::ST_SCAN: begin
				mem_we = 1'b1;
				mem_waddr = addr_q;
				mem_wdata = '0;
			end
			hme_pkg::ST_IDLE: mem_raddr = smp_idx;
			hme_pkg::ST_FRAC_GO: begin
				div_start = 1'b1;
				sqrt_start = 1'b1;
			end
			hme_pkg::ST_ERR1_GO: begin
				div_start = 1'b1;
				div_dividend = hme_pkg::DIV_W'({total_q, 23'd0});
				div_divisor = {1'b0, fv_q};
			end
			hme_pkg::ST_ERR2_GO: begin
				div_start = 1'b1;
				div_dividend = q1_q;
				div_divisor = {1'b0, root};
			end
			hme_pkg::ST_EMIT: out_load = !out_valid_q;
			default: ;
		endcase
	end

	hme_store #(
		.DEPTH(DEPTH)
	) u_store (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	hme_divider u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dividend),
		.divisor(div_divisor),
		.done(div_done),
		.quotient(div_quot)
	);

	hme_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(sqrt_start),
		.radicand({n_q, 32'd0}),
		.root(root)
	);

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	a_scan_no_sample_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hme_pkg::ST_SCAN) |-> !smp_valid_s1)
		else $error("Sample write-back overlaps the clearing walk.");

	a_found_needs_enough: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> enough_q)
		else $error("Median bin found without enough entries.");

	a_emit_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hme_pkg::ST_EMIT && !out_valid_q) |=> out_valid_q)
		else $error("Result was not loaded into the output register.");

endmodule

// File: bench/histogram_median_estimator_top_tb.sv
`timescale 1ns / 1ps

module histogram_median_estimator_top_tb;

	localparam int STORE_DEPTH = hme_pkg::MAX_BINS_DEF + 2;
	localparam logic [hme_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic MODE_ADD = 1'b0;
	localparam logic MODE_FINISH = 1'b1;
	localparam int SETTLE_CYCLES = 24;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	hme_pkg::in_item_t in_data;
	logic out_valid;
	logic out_stall;
	hme_pkg::out_item_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [hme_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [hme_pkg::CFG_DATA_W-1:0] cfg_data;

	logic signed [11:0] low_edge;
	logic [8:0] bin_setting;
	logic [15:0] entry_floor;
	logic [31:0] bin_store [STORE_DEPTH];
	logic [31:0] samples_seen;
	hme_pkg::out_item_t expected_medians [$];
	int mismatches;
	int burst_left;

	histogram_median_estimator_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic int used_bins();
		if (bin_setting == 0) return 1;
		if (bin_setting > hme_pkg::MAX_BINS_DEF) return hme_pkg::MAX_BINS_DEF;
		return int'(bin_setting);
	endfunction

	function automatic longint unsigned int_root(longint unsigned x);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic void clear_histogram();
		for (int k = 0; k < STORE_DEPTH; k++) bin_store[k] = '0;
		samples_seen = '0;
	endfunction

	function automatic void count_sample(logic signed [15:0] s);
		int whole;
		int rel;
		int nb;
		int idx;
		whole = int'(s >>> hme_pkg::SAMPLE_FRAC_BITS_DEF);
		rel = whole - int'(low_edge);
		nb = used_bins();
		if (rel < 0) idx = 0;
		else if (rel >= nb) idx = nb + 1;
		else idx = rel + 1;
		if (bin_store[idx] != hme_pkg::CNT_MAX) bin_store[idx]++;
		if (samples_seen != hme_pkg::CNT_MAX) samples_seen++;
	endfunction

	function automatic hme_pkg::out_item_t finish_median();
		hme_pkg::out_item_t r;
		longint unsigned total;
		longint unsigned csum;
		longint unsigned v;
		longint unsigned frac;
		longint unsigned rt;
		longint unsigned e;
		longint m;
		int last;
		int i;
		bit found;
		r = '0;
		total = 0;
		csum = 0;
		v = 0;
		found = 0;
		last = used_bins() + 1;
		r.enough_entries = samples_seen > entry_floor;
		r.entry_total = samples_seen;
		if (r.enough_entries) begin
			for (int k = 0; k <= last; k++) total += 64'(bin_store[k]);
			if (total != 0) begin
				for (i = 0; i <= last; i++) begin
					v = 64'(bin_store[i]);
					if (v == 0) continue;
					if (2 * (csum + v) < total) csum += v;
					else begin
						found = 1;
						break;
					end
				end
			end
			if (found) begin
				frac = (256 * (total - 2 * csum) + v) / (2 * v);
				m = (longint'(low_edge) + i - 1) * 256 + longint'(frac);
				r.median = m[23:0];
				rt = int_root(longint'(samples_seen) << 32);
				if (rt == 0) e = 64'(hme_pkg::RES_MAX);
				else begin
					e = ((total << 23) / v) / rt;
					if (e > 64'(hme_pkg::RES_MAX)) e = 64'(hme_pkg::RES_MAX);
				end
				r.median_error = e[23:0];
			end
		end
		clear_histogram();
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t: %s got %0d expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		hme_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_medians.size() == 0) begin
				report_mismatch("unexpected result, entry_total",
					longint'(out_data.entry_total), longint'(0));
			end else begin
				want = expected_medians.pop_front();
				if (out_data.median !== want.median)
					report_mismatch("median", longint'(out_data.median),
						longint'(want.median));
				if (out_data.median_error !== want.median_error)
					report_mismatch("median_error", longint'(out_data.median_error),
						longint'(want.median_error));
				if (out_data.enough_entries !== want.enough_entries)
					report_mismatch("enough_entries", longint'(out_data.enough_entries),
						longint'(want.enough_entries));
				if (out_data.entry_total !== want.entry_total)
					report_mismatch("entry_total", longint'(out_data.entry_total),
						longint'(want.entry_total));
			end
		end
	end

	initial begin
		int mode;
		int left;
		mode = 0;
		left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 2);
				left = $urandom_range(5, 60);
			end
			left--;
			case (mode)
				0: out_stall = 1'b0;
				1: out_stall = $urandom_range(0, 9) < 4;
				default: out_stall = $urandom_range(0, 9) < 8;
			endcase
		end
	end

	task automatic send_item(logic mode, logic signed [15:0] s);
		@(negedge clk);
		in_valid = 1'b1;
		in_data.mode = mode;
		in_data.sample = s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (mode == MODE_FINISH) expected_medians.push_back(finish_median());
		else count_sample(s);
		if (burst_left == 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
		end else begin
			burst_left--;
		end
	endtask

	task automatic wait_quiet();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_medians.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [hme_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
		wait_quiet();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			hme_pkg::REG_LOW_EDGE: low_edge = value[11:0];
			hme_pkg::REG_BINS: bin_setting = value[8:0];
			hme_pkg::REG_MIN_ENTRIES: entry_floor = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic signed [15:0] in_range_sample();
		int whole;
		whole = int'(low_edge) + $urandom_range(0, used_bins() + 3) - 2;
		if (whole < -2048 || whole > 2047) return 16'($urandom);
		return 16'(whole * 16 + $urandom_range(0, 15));
	endfunction

	task automatic test_reset_defaults();
		for (int k = 0; k < 12; k++) send_item(MODE_ADD, 16'(k * 16 + 8));
		send_item(MODE_FINISH, 16'($urandom));
		send_item(MODE_FINISH, '0);
	endtask

	task automatic test_field_extremes();
		write_reg(hme_pkg::REG_LOW_EDGE, 16'hF800);
		write_reg(hme_pkg::REG_BINS, 16'd256);
		write_reg(hme_pkg::REG_MIN_ENTRIES, 16'd0);
		send_item(MODE_ADD, 16'sh8000);
		send_item(MODE_ADD, 16'sh7FFF);
		send_item(MODE_ADD, 16'shFFFF);
		send_item(MODE_ADD, 16'sh0000);
		send_item(MODE_FINISH, 16'shFFFF);
		send_item(MODE_ADD, 16'sh5555);
		send_item(MODE_FINISH, 16'shAAAA);
		write_reg(hme_pkg::REG_LOW_EDGE, 16'h07FF);
		send_item(MODE_ADD, 16'sh7FF0);
		send_item(MODE_ADD, 16'sh7FFF);
		send_item(MODE_ADD, 16'sh8000);
		send_item(MODE_FINISH, 16'sh0000);
	endtask

	task automatic test_special_cases();
		write_reg(hme_pkg::REG_LOW_EDGE, 16'h0000);
		write_reg(hme_pkg::REG_MIN_ENTRIES, 16'd3);
		send_item(MODE_ADD, 16'sd40);
		send_item(MODE_ADD, 16'sd40);
		send_item(MODE_FINISH, '0);
		write_reg(hme_pkg::REG_MIN_ENTRIES, 16'hFFFF);
		send_item(MODE_ADD, 16'sd1);
		send_item(MODE_FINISH, '0);
		write_reg(hme_pkg::REG_MIN_ENTRIES, 16'd0);
		send_item(MODE_FINISH, '0);
		write_reg(hme_pkg::REG_BINS, 16'd0);
		send_item(MODE_ADD, 16'sd5);
		send_item(MODE_ADD, 16'sd20);
		send_item(MODE_ADD, -16'sd20);
		send_item(MODE_FINISH, '0);
		write_reg(hme_pkg::REG_BINS, 16'd511);
		send_item(MODE_ADD, 16'sd4000);
		send_item(MODE_ADD, 16'sd4100);
		send_item(MODE_FINISH, '0);
		// Samples land in the overflow bin of a wide histogram, which then shrinks.
		write_reg(hme_pkg::REG_BINS, 16'd100);
		send_item(MODE_ADD, 16'sd3000);
		send_item(MODE_ADD, 16'sd3000);
		write_reg(hme_pkg::REG_BINS, 16'd10);
		send_item(MODE_FINISH, '0);
		write_reg(REG_UNUSED, 16'hFFFF);
		send_item(MODE_ADD, 16'sd17);
		send_item(MODE_FINISH, '0);
	endtask

	task automatic test_random_steps();
		int sent;
		int n;
		sent = 0;
		while (sent < 900) begin
			write_reg(hme_pkg::REG_LOW_EDGE, 16'($urandom_range(0, 9) == 0 ?
				($urandom_range(0, 1) ? 2047 : -2048) : $urandom_range(0, 200) - 100));
			write_reg(hme_pkg::REG_BINS, 16'($urandom_range(0, 9) == 0 ?
				$urandom_range(0, 511) : $urandom_range(1, 40)));
			write_reg(hme_pkg::REG_MIN_ENTRIES, 16'($urandom_range(0, 9) == 0 ?
				$urandom : $urandom_range(0, 8)));
			repeat ($urandom_range(2, 6)) begin
				n = $urandom_range(1, 30);
				for (int k = 0; k < n; k++) begin
					if ($urandom_range(0, 4) == 0) send_item(MODE_ADD, 16'($urandom));
					else send_item(MODE_ADD, in_range_sample());
				end
				send_item(MODE_FINISH, 16'($urandom));
				sent += n + 1;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		burst_left = 0;
		low_edge = hme_pkg::LOW_EDGE_RST;
		bin_setting = hme_pkg::BINS_RST;
		entry_floor = hme_pkg::MIN_ENTRIES_RST;
		clear_histogram();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_field_extremes();
		test_special_cases();
		test_random_steps();

		wait_quiet();
		repeat (800) @(negedge clk);
		if (mismatches == 0 && expected_medians.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

// File: files.f
hdl/hme_pkg.sv
hdl/hme_store.sv
hdl/hme_divider.sv
hdl/hme_sqrt.sv
hdl/histogram_median_estimator_top.sv
bench/histogram_median_estimator_top_tb.sv
